@@ rtl/lfu_lru_tiebreak_replacement_defines.svh @@
// Assertion macros for the LFU replacement block.
`ifndef LFU_LRU_TIEBREAK_REPLACEMENT_DEFINES_SVH
`define LFU_LRU_TIEBREAK_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu replacement: implication check failed");
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu replacement: next-cycle check failed");
`else
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lfulru_pkg.sv @@
// Shared types and constants of the LFU replacement block.
package lfulru_pkg;

  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned STAMP_W      = 48;
  localparam int unsigned SET_IDX_W    = 11;
  localparam int unsigned WAY_IDX_W    = 4;
  localparam int unsigned DEF_NUM_SETS = 2048;
  localparam int unsigned DEF_NUM_WAYS = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_FILL = COUNT_W'(1);

  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_RESP,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic load;
    logic reduce;
    logic write;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
  } dp_status_t;

endpackage

@@ rtl/lfulru_ctrl.sv @@
// Controller state machine of the LFU replacement block.
module lfulru_ctrl #(
  parameter int unsigned NUM_WAYS = lfulru_pkg::DEF_NUM_WAYS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   action_i,
  input  lfulru_pkg::dp_status_t status_i,
  output logic                   busy,
  output logic                   victim_valid_o,
  output lfulru_pkg::dp_cmd_t    cmd_o
);

  localparam int unsigned LVL   = $clog2(NUM_WAYS);
  localparam int unsigned LVL_W = $clog2(LVL + 1);

  lfulru_pkg::ctrl_state_e state_q, state_d;
  logic [LVL_W-1:0]        lvl_q, lvl_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lfulru_pkg::ST_CLEAR: begin
        if (status_i.clr_done) state_d = lfulru_pkg::ST_IDLE;
      end
      lfulru_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (action_i == lfulru_pkg::ACT_UPDATE) ? lfulru_pkg::ST_WRITE
                                                         : lfulru_pkg::ST_LOAD;
        end
      end
      lfulru_pkg::ST_LOAD: begin
        state_d = lfulru_pkg::ST_REDUCE;
      end
      lfulru_pkg::ST_REDUCE: begin
        if (lvl_q == LVL_W'(LVL - 1)) state_d = lfulru_pkg::ST_RESP;
      end
      lfulru_pkg::ST_RESP: begin
        state_d = lfulru_pkg::ST_IDLE;
      end
      lfulru_pkg::ST_WRITE: begin
        state_d = lfulru_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfulru_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    lvl_d = (state_q == lfulru_pkg::ST_REDUCE) ? lvl_q + 1'b1 : '0;
  end

  always_comb begin
    cmd_o          = '0;
    busy           = 1'b1;
    victim_valid_o = 1'b0;
    case (state_q)
      lfulru_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      lfulru_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      lfulru_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      lfulru_pkg::ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
      end
      lfulru_pkg::ST_RESP: begin
        victim_valid_o = 1'b1;
      end
      lfulru_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfulru_pkg::ST_CLEAR;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

endmodule

@@ rtl/lfulru_dp.sv @@
// Datapath of the LFU replacement block: set memory, update logic, victim compare tree.
module lfulru_dp #(
  parameter int unsigned NUM_SETS = lfulru_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS = lfulru_pkg::DEF_NUM_WAYS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lfulru_pkg::dp_cmd_t                  cmd_i,
  output lfulru_pkg::dp_status_t               status_o,
  input  logic [lfulru_pkg::SET_IDX_W-1:0]     set_index_i,
  input  logic [lfulru_pkg::WAY_IDX_W-1:0]     way_index_i,
  input  logic                                 hit_i,
  input  logic [lfulru_pkg::STAMP_W-1:0]       time_stamp_i,
  output logic [lfulru_pkg::WAY_IDX_W-1:0]     victim_way_o
);

  localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam int unsigned PAD   = 1 << WAY_W;
  localparam int unsigned VW    = lfulru_pkg::WAY_IDX_W;

  typedef lfulru_pkg::entry_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    lfulru_pkg::entry_t e;
    logic [WAY_W-1:0]   way;
  } slot_t;

  row_t                           mem_q [NUM_SETS];
  row_t                           rdata_q;
  row_t                           wr_row;
  logic [SET_W-1:0]               clr_q;
  logic [SET_W-1:0]               rd_addr;
  logic [SET_W-1:0]               addr_q;
  logic [WAY_W-1:0]               way_q;
  logic                           hit_q;
  logic [lfulru_pkg::STAMP_W-1:0] stamp_q;
  logic                           set_ok_q;
  logic                           way_ok_q;
  logic                           wr_en;
  lfulru_pkg::entry_t             cur;
  slot_t                          slot_q [PAD];
  slot_t                          slot_d [PAD];

  function automatic slot_t pick(slot_t a, slot_t b);
    logic b_wins;
    b_wins = (b.e.count < a.e.count) ||
             ((b.e.count == a.e.count) && (b.e.stamp < a.e.stamp));
    return b_wins ? b : a;
  endfunction

  assign status_o.clr_done = (clr_q == SET_W'(NUM_SETS - 1));
  assign rd_addr           = SET_W'(set_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step && !status_o.clr_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q   <= rd_addr;
      way_q    <= WAY_W'(way_index_i);
      hit_q    <= hit_i;
      stamp_q  <= time_stamp_i;
      set_ok_q <= (32'(set_index_i) < NUM_SETS);
      way_ok_q <= (32'(way_index_i) < NUM_WAYS);
    end
  end

  assign wr_en = cmd_i.write && set_ok_q && way_ok_q;

  always_comb begin
    wr_row    = rdata_q;
    cur       = rdata_q[way_q];
    cur.stamp = stamp_q;
    if (hit_q) begin
      if (cur.count != lfulru_pkg::COUNT_MAX) cur.count = cur.count + 1'b1;
    end else begin
      cur.count = lfulru_pkg::COUNT_FILL;
    end
    wr_row[way_q] = cur;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en) begin
      mem_q[addr_q] <= wr_row;
    end
    if (cmd_i.capture) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.load) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        slot_d[i].e   = rdata_q[i];
        slot_d[i].way = WAY_W'(i);
      end
      for (int i = NUM_WAYS; i < PAD; i++) begin
        slot_d[i].e   = '1;
        slot_d[i].way = WAY_W'(i);
      end
    end else if (cmd_i.reduce) begin
      for (int i = 0; i < PAD / 2; i++) begin
        slot_d[i] = pick(slot_q[2 * i], slot_q[2 * i + 1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign victim_way_o = set_ok_q ? VW'(slot_q[0].way) : '0;

endmodule

@@ rtl/lfu_lru_tiebreak_replacement.sv @@
// Top level of the LFU replacement policy with LRU tie-break.
//
//   channel   direction  handshake                 words
//   command   in         start high, busy low      action, set, way, hit, time stamp
//   result    out        victim_valid_o one cycle  victim way
//
// An update: memory read at accept, row write-back in the next cycle.
// A query: read at accept, load, one compare-tree level per cycle, then the result strobe;
// the single set memory port and the shared compare tree set this order.
// After reset a clearing pass writes all NUM_SETS sets, one per cycle, with busy high.
// Results cannot be stalled; busy covers every cycle of work.
`include "lfu_lru_tiebreak_replacement_defines.svh"

module lfu_lru_tiebreak_replacement #(
  parameter int unsigned NUM_SETS = lfulru_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS = lfulru_pkg::DEF_NUM_WAYS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action_i,
  input  logic [lfulru_pkg::SET_IDX_W-1:0] set_index_i,
  input  logic [lfulru_pkg::WAY_IDX_W-1:0] way_index_i,
  input  logic                             hit_i,
  input  logic [lfulru_pkg::STAMP_W-1:0]   time_stamp_i,
  output logic                             victim_valid_o,
  output logic [lfulru_pkg::WAY_IDX_W-1:0] victim_way_o
);

  lfulru_pkg::dp_cmd_t    cmd;
  lfulru_pkg::dp_status_t status;
  logic                   qry_acc;
  logic                   upd_acc;

  lfulru_ctrl #(
    .NUM_WAYS(NUM_WAYS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .action_i      (action_i),
    .status_i      (status),
    .busy          (busy),
    .victim_valid_o(victim_valid_o),
    .cmd_o         (cmd)
  );

  lfulru_dp #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .set_index_i (set_index_i),
    .way_index_i (way_index_i),
    .hit_i       (hit_i),
    .time_stamp_i(time_stamp_i),
    .victim_way_o(victim_way_o)
  );

  assign qry_acc = start && !busy && (action_i == lfulru_pkg::ACT_QUERY);
  assign upd_acc = start && !busy && (action_i == lfulru_pkg::ACT_UPDATE);

  `LFU_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, victim_valid_o, !victim_valid_o && !busy)
  `LFU_ASSERT_NXT(a_update_silent, clk_i, rst_ni, upd_acc, busy && !victim_valid_o)
  `LFU_ASSERT_NXT(a_query_pending, clk_i, rst_ni, qry_acc, busy && !victim_valid_o)
  `LFU_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, victim_valid_o, busy && !cmd.capture)

endmodule
